// ----- hw/rtl/bpc_pkg.sv -----
// Shared widths, types and arithmetic helpers for the barometer compensation pipeline.
package bpc_pkg;

   localparam int FRAC_BITS  = 24;
   localparam int QW         = 32 + FRAC_BITS;
   localparam int MAG_W      = QW - 1;
   localparam int LO_W       = (MAG_W + 1) / 2;
   localparam int HI_W       = MAG_W - LO_W;
   localparam int LL_W       = 2 * LO_W;
   localparam int MID_W      = LO_W + HI_W;
   localparam int HH_W       = 2 * HI_W;
   localparam int PROD_W     = 2 * MAG_W + 1;
   localparam int RND_W      = PROD_W - FRAC_BITS;

   localparam int RAW_W      = 24;
   localparam int OUT_W      = 32;
   localparam int COEF_W     = 20;
   localparam int SCALE_W    = 23;
   localparam int DEN_W      = SCALE_W + 1;
   localparam int NUM_W      = RAW_W + FRAC_BITS + 1;
   localparam int DIV_W      = NUM_W + (NUM_W % 2);
   localparam int DIV_BITS   = 2;
   localparam int DIV_STAGES = DIV_W / DIV_BITS;

   localparam int MAC_LAT    = 6;
   localparam int LAT_LAST   = MAC_LAT - 1;
   localparam int NUM_LVL    = 5;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 64;
   localparam int CAL_T_W    = 24;
   localparam int CAL_A_W    = 40;
   localparam int CAL_B_W    = 64;
   localparam int CAL_C_W    = 16;

   localparam logic [SCALE_W-1:0] PRES_SCALE_RESET = SCALE_W'(1040384);
   localparam logic [SCALE_W-1:0] TEMP_SCALE_RESET = SCALE_W'(524288);

   typedef logic signed [QW-1:0] qval_type;

   localparam qval_type QVAL_MAX = qval_type'((QW'(1) << MAG_W) - QW'(1));
   localparam qval_type QVAL_MIN = -QVAL_MAX;

   localparam logic [QW-1:0] Q8_POS_LIM = (QW'(1) << (OUT_W - 1)) - QW'(1);
   localparam logic [QW-1:0] Q8_NEG_LIM = QW'(1) << (OUT_W - 1);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TEMP_CAL   = 3'd0,
      CSR_PRES_CAL_A = 3'd1,
      CSR_PRES_CAL_B = 3'd2,
      CSR_PRES_CAL_C = 3'd3,
      CSR_PRES_SCALE = 3'd4,
      CSR_TEMP_SCALE = 3'd5
   } csr_idx_type;

   typedef struct packed {
      logic             neg;
      logic [DEN_W-1:0] rem;
      logic [DIV_W-1:0] nq;
   } div_type;

   typedef struct packed {
      qval_type ps;
      qval_type ts;
      qval_type t;
      qval_type q;
      qval_type tp;
      logic     sat;
   } carry_type;

   typedef struct packed {
      logic [OUT_W-1:0] value;
      logic             sat;
   } q8_type;

   // One restoring division step: the numerator shifts out at the top while
   // quotient bits shift in at the bottom.
   function automatic div_type div_step(input div_type x, input logic [DEN_W-1:0] d);
      logic [DEN_W:0] t;
      div_type        y;
      t = {x.rem, x.nq[DIV_W-1]};
      y = x;
      y.nq = {x.nq[DIV_W-2:0], 1'b0};
      if (t >= {1'b0, d}) begin
         y.rem = DEN_W'(t - {1'b0, d});
         y.nq[0] = 1'b1;
      end else begin
         y.rem = t[DEN_W-1:0];
      end
      return y;
   endfunction

   function automatic qval_type coef_q(input logic signed [COEF_W-1:0] c);
      qval_type v;
      v = QW'(c);
      return v <<< FRAC_BITS;
   endfunction

   // Rounds half away from zero into 1/256 units and clamps to 32 bits.
   function automatic q8_type to_q8(input qval_type x);
      logic [QW-1:0] mag;
      logic [QW-1:0] r;
      q8_type        o;
      mag = x[QW-1] ? QW'(-x) : QW'(x);
      r = (mag + (QW'(1) << (FRAC_BITS - 9))) >> (FRAC_BITS - 8);
      o.sat = 1'b0;
      if (x[QW-1]) begin
         if (r > Q8_NEG_LIM) begin
            r = Q8_NEG_LIM;
            o.sat = 1'b1;
         end
         o.value = OUT_W'(QW'(0) - r);
      end else begin
         if (r > Q8_POS_LIM) begin
            r = Q8_POS_LIM;
            o.sat = 1'b1;
         end
         o.value = OUT_W'(r);
      end
      return o;
   endfunction

endpackage

// ----- hw/rtl/barometer_pressure_compensation.sv -----
// Top level of the pipelined barometer pressure and temperature compensation.
//
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  raw_pressure, raw_temperature
//   rsp_      out        rsp_valid / rsp_stall  pressure_out, temperature_out, saturated
//   csr_      in         csr_write_enable       csr_index, csr_data
//
// One item enters per cycle while the output is not stalled. From acceptance to rsp_valid each item
// passes the two 2-bit-per-stage dividers (an input register and 25 stages), the signed-quotient
// register, five chained levels of six-stage multiply-add units that evaluate the polynomials,
// and then the output register.
// Reset clears the valid bits and loads the register defaults.
// A stalled output freezes the whole pipeline, so req_stall follows rsp_stall
// while a result is waiting.
module barometer_pressure_compensation (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic signed [bpc_pkg::RAW_W-1:0]     req_raw_pressure,
   input  logic signed [bpc_pkg::RAW_W-1:0]     req_raw_temperature,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic signed [bpc_pkg::OUT_W-1:0]     rsp_pressure_out,
   output logic signed [bpc_pkg::OUT_W-1:0]     rsp_temperature_out,
   output logic                                 rsp_saturated,
   input  logic                                 csr_write_enable,
   input  logic [bpc_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [bpc_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bpc_pkg::*;

   logic [CAL_T_W-1:0] cal_t_ff, cal_t_in;
   logic [CAL_A_W-1:0] cal_a_ff, cal_a_in;
   logic [CAL_B_W-1:0] cal_b_ff, cal_b_in;
   logic [CAL_C_W-1:0] cal_c_ff, cal_c_in;
   logic [SCALE_W-1:0] scale_p_ff, scale_p_in;
   logic [SCALE_W-1:0] scale_t_ff, scale_t_in;

   logic               adv;

   qval_type c0h, c1q, c00q, c10q, c01q, c11q, c20q, c21q, c30q;
   logic [SCALE_W-1:0] kp_eff, kt_eff;
   logic [DEN_W-1:0]   dp, dt;
   logic [RAW_W-1:0]   magp, magt;

   div_type   divp_ff [DIV_STAGES+1];
   div_type   divp_in [DIV_STAGES+1];
   div_type   divt_ff [DIV_STAGES+1];
   div_type   divt_in [DIV_STAGES+1];
   logic      div_vld_ff [DIV_STAGES+1];
   logic      div_vld_in [DIV_STAGES+1];

   qval_type  ps_ff, ps_in, ts_ff, ts_in;
   logic      sg_vld_ff, sg_vld_in;

   carry_type lv_ff [NUM_LVL][MAC_LAT];
   carry_type lv_in [NUM_LVL][MAC_LAT];
   logic      lv_vld_ff [NUM_LVL][MAC_LAT];
   logic      lv_vld_in [NUM_LVL][MAC_LAT];

   qval_type  t_res, p1_res, q_res, tp_res, p2_res, p3_res, p4_res, p5_res;
   logic      t_sat, p1_sat, q_sat, tp_sat, p2_sat, p3_sat, p4_sat, p5_sat;

   q8_type    q8p, q8t;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic signed [OUT_W-1:0] rsp_p_ff, rsp_p_in, rsp_t_ff, rsp_t_in;
   logic                    rsp_sat_ff, rsp_sat_in;

   // Configuration writes.
   always_comb begin
      cal_t_in   = cal_t_ff;
      cal_a_in   = cal_a_ff;
      cal_b_in   = cal_b_ff;
      cal_c_in   = cal_c_ff;
      scale_p_in = scale_p_ff;
      scale_t_in = scale_t_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_TEMP_CAL:   cal_t_in   = csr_data[CAL_T_W-1:0];
            CSR_PRES_CAL_A: cal_a_in   = csr_data[CAL_A_W-1:0];
            CSR_PRES_CAL_B: cal_b_in   = csr_data[CAL_B_W-1:0];
            CSR_PRES_CAL_C: cal_c_in   = csr_data[CAL_C_W-1:0];
            CSR_PRES_SCALE: scale_p_in = csr_data[SCALE_W-1:0];
            CSR_TEMP_SCALE: scale_t_in = csr_data[SCALE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_t_ff   <= '0;
         cal_a_ff   <= '0;
         cal_b_ff   <= '0;
         cal_c_ff   <= '0;
         scale_p_ff <= PRES_SCALE_RESET;
         scale_t_ff <= TEMP_SCALE_RESET;
      end else begin
         cal_t_ff   <= cal_t_in;
         cal_a_ff   <= cal_a_in;
         cal_b_ff   <= cal_b_in;
         cal_c_ff   <= cal_c_in;
         scale_p_ff <= scale_p_in;
         scale_t_ff <= scale_t_in;
      end
   end

   // Coefficients must be kept static by the user while items are in flight; the block does not enforce it.
   assign c0h  = coef_q(COEF_W'(signed'(cal_t_ff[23:12]))) >>> 1;
   assign c1q  = coef_q(COEF_W'(signed'(cal_t_ff[11:0])));
   assign c00q = coef_q(signed'(cal_a_ff[39:20]));
   assign c10q = coef_q(signed'(cal_a_ff[19:0]));
   assign c01q = coef_q(COEF_W'(signed'(cal_b_ff[63:48])));
   assign c11q = coef_q(COEF_W'(signed'(cal_b_ff[47:32])));
   assign c20q = coef_q(COEF_W'(signed'(cal_b_ff[31:16])));
   assign c21q = coef_q(COEF_W'(signed'(cal_b_ff[15:0])));
   assign c30q = coef_q(COEF_W'(signed'(cal_c_ff)));

   assign kp_eff = (scale_p_ff == '0) ? SCALE_W'(1) : scale_p_ff;
   assign kt_eff = (scale_t_ff == '0) ? SCALE_W'(1) : scale_t_ff;
   assign dp     = {kp_eff, 1'b0};
   assign dt     = {kt_eff, 1'b0};

   assign magp = req_raw_pressure[RAW_W-1]    ? RAW_W'(-req_raw_pressure)
                                              : RAW_W'(req_raw_pressure);
   assign magt = req_raw_temperature[RAW_W-1] ? RAW_W'(-req_raw_temperature)
                                              : RAW_W'(req_raw_temperature);

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   // Rounded quotient (2*mag*2^FRAC_BITS + k) / (2*k), two quotient bits per stage.
   always_comb begin
      div_type xp;
      div_type xt;
      divp_in[0].neg = req_raw_pressure[RAW_W-1];
      divp_in[0].rem = '0;
      divp_in[0].nq  = (DIV_W'(magp) << (FRAC_BITS + 1)) + DIV_W'(kp_eff);
      divt_in[0].neg = req_raw_temperature[RAW_W-1];
      divt_in[0].rem = '0;
      divt_in[0].nq  = (DIV_W'(magt) << (FRAC_BITS + 1)) + DIV_W'(kt_eff);
      div_vld_in[0]  = req_valid;
      for (int j = 0; j < DIV_STAGES; j++) begin
         xp = divp_ff[j];
         xt = divt_ff[j];
         for (int k = 0; k < DIV_BITS; k++) begin
            xp = div_step(xp, dp);
            xt = div_step(xt, dt);
         end
         divp_in[j+1]    = xp;
         divt_in[j+1]    = xt;
         div_vld_in[j+1] = div_vld_ff[j];
      end

      ps_in = divp_ff[DIV_STAGES].neg ? -qval_type'(divp_ff[DIV_STAGES].nq)
                                      : qval_type'(divp_ff[DIV_STAGES].nq);
      ts_in = divt_ff[DIV_STAGES].neg ? -qval_type'(divt_ff[DIV_STAGES].nq)
                                      : qval_type'(divt_ff[DIV_STAGES].nq);
      sg_vld_in = div_vld_ff[DIV_STAGES];
   end

   // Side data that rides alongside each level of multiply-add units.
   always_comb begin
      for (int l = 0; l < NUM_LVL; l++) begin
         for (int i = 1; i < MAC_LAT; i++) begin
            lv_in[l][i]     = lv_ff[l][i-1];
            lv_vld_in[l][i] = lv_vld_ff[l][i-1];
         end
      end

      lv_in[0][0].ps  = ps_ff;
      lv_in[0][0].ts  = ts_ff;
      lv_in[0][0].t   = '0;
      lv_in[0][0].q   = '0;
      lv_in[0][0].tp  = '0;
      lv_in[0][0].sat = 1'b0;
      lv_vld_in[0][0] = sg_vld_ff;

      lv_in[1][0]     = lv_ff[0][LAT_LAST];
      lv_in[1][0].t   = t_res;
      lv_in[1][0].q   = q_res;
      lv_in[1][0].tp  = tp_res;
      lv_in[1][0].sat = lv_ff[0][LAT_LAST].sat | t_sat | p1_sat | q_sat | tp_sat;
      lv_vld_in[1][0] = lv_vld_ff[0][LAT_LAST];

      lv_in[2][0]     = lv_ff[1][LAT_LAST];
      lv_in[2][0].sat = lv_ff[1][LAT_LAST].sat | p2_sat;
      lv_vld_in[2][0] = lv_vld_ff[1][LAT_LAST];

      lv_in[3][0]     = lv_ff[2][LAT_LAST];
      lv_in[3][0].sat = lv_ff[2][LAT_LAST].sat | p3_sat;
      lv_vld_in[3][0] = lv_vld_ff[2][LAT_LAST];

      lv_in[4][0]     = lv_ff[3][LAT_LAST];
      lv_in[4][0].sat = lv_ff[3][LAT_LAST].sat | p4_sat;
      lv_vld_in[4][0] = lv_vld_ff[3][LAT_LAST];

      q8p          = to_q8(p5_res);
      q8t          = to_q8(lv_ff[4][LAT_LAST].t);
      rsp_valid_in = lv_vld_ff[4][LAT_LAST];
      rsp_p_in     = signed'(q8p.value);
      rsp_t_in     = signed'(q8t.value);
      rsp_sat_in   = lv_ff[4][LAT_LAST].sat | p5_sat | q8p.sat | q8t.sat;
   end

   // Temperature and the first terms of the pressure polynomial.
   bpc_mac u_mac_t (
      .clock(clock), .en(adv), .a(c1q), .b(ts_ff), .addend(c0h),
      .res(t_res), .sat(t_sat)
   );
   bpc_mac u_mac_p1 (
      .clock(clock), .en(adv), .a(ps_ff), .b(c30q), .addend(c20q),
      .res(p1_res), .sat(p1_sat)
   );
   bpc_mac u_mac_q (
      .clock(clock), .en(adv), .a(ps_ff), .b(c21q), .addend(c11q),
      .res(q_res), .sat(q_sat)
   );
   bpc_mac u_mac_tp (
      .clock(clock), .en(adv), .a(ts_ff), .b(ps_ff), .addend('0),
      .res(tp_res), .sat(tp_sat)
   );

   // Horner chain for the pressure terms, then the cross terms.
   bpc_mac u_mac_p2 (
      .clock(clock), .en(adv), .a(lv_ff[0][LAT_LAST].ps), .b(p1_res), .addend(c10q),
      .res(p2_res), .sat(p2_sat)
   );
   bpc_mac u_mac_p3 (
      .clock(clock), .en(adv), .a(lv_ff[1][LAT_LAST].ps), .b(p2_res), .addend(c00q),
      .res(p3_res), .sat(p3_sat)
   );
   bpc_mac u_mac_p4 (
      .clock(clock), .en(adv), .a(lv_ff[2][LAT_LAST].ts), .b(c01q), .addend(p3_res),
      .res(p4_res), .sat(p4_sat)
   );
   bpc_mac u_mac_p5 (
      .clock(clock), .en(adv), .a(lv_ff[3][LAT_LAST].tp), .b(lv_ff[3][LAT_LAST].q),
      .addend(p4_res), .res(p5_res), .sat(p5_sat)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            div_vld_ff[j] <= 1'b0;
         end
         sg_vld_ff <= 1'b0;
         for (int l = 0; l < NUM_LVL; l++) begin
            for (int i = 0; i < MAC_LAT; i++) begin
               lv_vld_ff[l][i] <= 1'b0;
            end
         end
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            div_vld_ff[j] <= div_vld_in[j];
         end
         sg_vld_ff <= sg_vld_in;
         for (int l = 0; l < NUM_LVL; l++) begin
            for (int i = 0; i < MAC_LAT; i++) begin
               lv_vld_ff[l][i] <= lv_vld_in[l][i];
            end
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j <= DIV_STAGES; j++) begin
            divp_ff[j] <= divp_in[j];
            divt_ff[j] <= divt_in[j];
         end
         ps_ff <= ps_in;
         ts_ff <= ts_in;
         for (int l = 0; l < NUM_LVL; l++) begin
            for (int i = 0; i < MAC_LAT; i++) begin
               lv_ff[l][i] <= lv_in[l][i];
            end
         end
         rsp_p_ff   <= rsp_p_in;
         rsp_t_ff   <= rsp_t_in;
         rsp_sat_ff <= rsp_sat_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_pressure_out    = rsp_p_ff;
   assign rsp_temperature_out = rsp_t_ff;
   assign rsp_saturated       = rsp_sat_ff;

endmodule

// ----- hw/rtl/bpc_mac.sv -----
// Six-stage fixed-point multiply-add with rounding and clamping of product and sum.
module bpc_mac (
   input  logic              clock,
   input  logic              en,
   input  bpc_pkg::qval_type a,
   input  bpc_pkg::qval_type b,
   input  bpc_pkg::qval_type addend,
   output bpc_pkg::qval_type res,
   output logic              sat
);
   import bpc_pkg::*;

   logic [MAG_W-1:0]  ma_ff, ma_in, mb_ff, mb_in;
   logic              neg1_ff, neg1_in;
   qval_type          add1_ff, add1_in;

   logic [LL_W-1:0]   ll_ff, ll_in;
   logic [MID_W-1:0]  lh_ff, lh_in, hl_ff, hl_in;
   logic [HH_W-1:0]   hh_ff, hh_in;
   logic              neg2_ff, neg2_in;
   qval_type          add2_ff, add2_in;

   logic [LL_W:0]     llr_ff, llr_in;
   logic [MID_W:0]    mid_ff, mid_in;
   logic [HH_W-1:0]   hh3_ff, hh3_in;
   logic              neg3_ff, neg3_in;
   qval_type          add3_ff, add3_in;

   logic [RND_W-1:0]  rnd_ff, rnd_in;
   logic              neg4_ff, neg4_in;
   qval_type          add4_ff, add4_in;

   qval_type          mul_ff, mul_in;
   logic              msat_ff, msat_in;
   qval_type          add5_ff, add5_in;

   qval_type          res_ff, res_in;
   logic              sat_ff, sat_in;

   logic [PROD_W-1:0] prod;
   logic [MAG_W-1:0]  mag5;
   logic signed [QW:0] sum6;

   always_comb begin
      ma_in   = a[QW-1] ? MAG_W'(-a) : MAG_W'(a);
      mb_in   = b[QW-1] ? MAG_W'(-b) : MAG_W'(b);
      neg1_in = a[QW-1] ^ b[QW-1];
      add1_in = addend;

      // Four partial products of the two halves of each magnitude.
      ll_in   = LL_W'(ma_ff[LO_W-1:0]) * LL_W'(mb_ff[LO_W-1:0]);
      lh_in   = MID_W'(ma_ff[LO_W-1:0]) * MID_W'(mb_ff[MAG_W-1:LO_W]);
      hl_in   = MID_W'(ma_ff[MAG_W-1:LO_W]) * MID_W'(mb_ff[LO_W-1:0]);
      hh_in   = HH_W'(ma_ff[MAG_W-1:LO_W]) * HH_W'(mb_ff[MAG_W-1:LO_W]);
      neg2_in = neg1_ff;
      add2_in = add1_ff;

      llr_in  = (LL_W+1)'(ll_ff) + ((LL_W+1)'(1) << (FRAC_BITS - 1));
      mid_in  = (MID_W+1)'(lh_ff) + (MID_W+1)'(hl_ff);
      hh3_in  = hh_ff;
      neg3_in = neg2_ff;
      add3_in = add2_ff;

      prod    = PROD_W'(llr_ff) + (PROD_W'(mid_ff) << LO_W) + (PROD_W'(hh3_ff) << LL_W);
      rnd_in  = prod[PROD_W-1:FRAC_BITS];
      neg4_in = neg3_ff;
      add4_in = add3_ff;

      if (rnd_ff > RND_W'(QVAL_MAX)) begin
         mag5    = QVAL_MAX[MAG_W-1:0];
         msat_in = 1'b1;
      end else begin
         mag5    = MAG_W'(rnd_ff);
         msat_in = 1'b0;
      end
      mul_in  = neg4_ff ? -qval_type'(mag5) : qval_type'(mag5);
      add5_in = add4_ff;

      sum6 = (QW+1)'(add5_ff) + (QW+1)'(mul_ff);
      if (sum6 > (QW+1)'(QVAL_MAX)) begin
         res_in = QVAL_MAX;
         sat_in = 1'b1;
      end else if (sum6 < (QW+1)'(QVAL_MIN)) begin
         res_in = QVAL_MIN;
         sat_in = 1'b1;
      end else begin
         res_in = QW'(sum6);
         sat_in = msat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ma_ff   <= ma_in;
         mb_ff   <= mb_in;
         neg1_ff <= neg1_in;
         add1_ff <= add1_in;
         ll_ff   <= ll_in;
         lh_ff   <= lh_in;
         hl_ff   <= hl_in;
         hh_ff   <= hh_in;
         neg2_ff <= neg2_in;
         add2_ff <= add2_in;
         llr_ff  <= llr_in;
         mid_ff  <= mid_in;
         hh3_ff  <= hh3_in;
         neg3_ff <= neg3_in;
         add3_ff <= add3_in;
         rnd_ff  <= rnd_in;
         neg4_ff <= neg4_in;
         add4_ff <= add4_in;
         mul_ff  <= mul_in;
         msat_ff <= msat_in;
         add5_ff <= add5_in;
         res_ff  <= res_in;
         sat_ff  <= sat_in;
      end
   end

   assign res = res_ff;
   assign sat = sat_ff;

endmodule
